### sv/ddf_pkg.sv
// Shared types and constants of the duplicate frame filter.
package ddf_pkg;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [7:0]  frame_id;
    logic [7:0]  seq_num;
    logic [15:0] life;
  } entry_t;

  localparam int KEY_W = 48;
  localparam int LIFE_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;
  localparam int COUNT_OUT_W = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_TYPE_MASK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LIFE  = 1'b1;

  localparam logic [63:0]       TYPE_MASK_RESET = 64'd0;
  localparam logic [LIFE_W-1:0] MAX_LIFE_RESET  = 16'd7000;

endpackage

### sv/duplicate_frame_filter.sv
// Duplicate frame filter: frame table in one memory, searched and aged by a sequencer.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | func, type_id, src_addr, frame_id, seq_num,
//          |           |                        | elapsed
//  out     | output    | out_valid / out_stall  | is_duplicate, entry_count
//  cfg     | input     | cfg_we                 | cfg_addr, cfg_wdata
//
// A check searches the live entries in order; the search reads one entry a cycle.
// A refresh walks the table top down: a kept entry is read, then written back aged, and a
// deleted one below the last is refilled from the last, through the single memory port pair.
// One word is in progress at a time; the result waits in an output register under stall.
// Reset empties the table at once through the live count; no clearing pass is needed.
module duplicate_frame_filter
  import ddf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [5:0]             in_type_id,
  input  logic [31:0]            in_src_addr,
  input  logic [7:0]             in_frame_id,
  input  logic [7:0]             in_seq_num,
  input  logic [15:0]            in_elapsed,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_is_duplicate,
  output logic [COUNT_OUT_W-1:0] out_entry_count,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRCH  = 3'd1;
  localparam logic [2:0] ST_RRD   = 3'd2;
  localparam logic [2:0] ST_REVAL = 3'd3;
  localparam logic [2:0] ST_RMOVE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [63:0] mem [TABLE_DEPTH];
  entry_t      rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              dup_r, dup_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [LIFE_W-1:0] elapsed_r;
  logic [63:0]       type_mask_r;
  logic [LIFE_W-1:0] max_life_r;
  logic              out_valid_r;
  logic              out_dup_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic              in_fire;
  logic              out_free;
  logic [CW-1:0]     count_dec;
  logic [CW-1:0]     idx_dec;
  logic              hit;
  logic              keep;
  logic [31:0]       count_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign count_dec = count_r - ONE_C;
  assign idx_dec   = idx_r - ONE_C;
  assign hit       = ({rd_data_r.src_addr, rd_data_r.frame_id, rd_data_r.seq_num} == key_r);
  assign keep      = (rd_data_r.life <= max_life_r) && (rd_data_r.life > elapsed_r);
  assign count_ext = 32'(count_r);

  assign out_valid        = out_valid_r;
  assign out_is_duplicate = out_dup_r;
  assign out_entry_count  = out_count_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    dup_nxt     = dup_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r[AW-1:0];
    mem_wdata   = {key_r, max_life_r};
    mem_raddr   = idx_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          dup_nxt = 1'b0;
          if (in_func) begin
            idx_nxt   = count_r;
            state_nxt = ST_RRD;
          end else if (type_mask_r[in_type_id]) begin
            idx_nxt   = '0;
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SRCH: begin
        if (cmp_vld_r && hit) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r;
          dup_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if ((count_r == '0) || (cmp_vld_r && (CW'(cmp_idx_r) == count_dec))) begin
          if (count_r < DEPTH_C) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            count_nxt = count_r + ONE_C;
          end
          state_nxt = ST_DONE;
        end else begin
          cmp_vld_nxt = (idx_r < count_r);
          cmp_idx_nxt = idx_r[AW-1:0];
          if (idx_r < count_r) begin
            idx_nxt = idx_r + ONE_C;
          end
        end
      end
      ST_RRD: begin
        if (idx_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          mem_raddr = idx_dec[AW-1:0];
          idx_nxt   = idx_dec;
          state_nxt = ST_REVAL;
        end
      end
      ST_REVAL: begin
        if (keep) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_data_r.src_addr, rd_data_r.frame_id, rd_data_r.seq_num,
                       LIFE_W'(rd_data_r.life - elapsed_r)};
          state_nxt = ST_RRD;
        end else if (idx_r != count_dec) begin
          mem_raddr = count_dec[AW-1:0];
          state_nxt = ST_RMOVE;
        end else begin
          count_nxt = count_dec;
          state_nxt = ST_RRD;
        end
      end
      ST_RMOVE: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        count_nxt = count_dec;
        state_nxt = ST_RRD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      type_mask_r <= TYPE_MASK_RESET;
      max_life_r  <= MAX_LIFE_RESET;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TYPE_MASK: type_mask_r <= cfg_wdata;
          CFG_MAX_LIFE:  max_life_r  <= cfg_wdata[LIFE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    dup_r     <= dup_nxt;
    if (in_fire) begin
      key_r     <= {in_src_addr, in_frame_id, in_seq_num};
      elapsed_r <= in_elapsed;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_dup_r   <= dup_r;
      out_count_r <= count_ext[COUNT_OUT_W-1:0];
    end
  end

endmodule

### sv/ddf_checker.sv
// Port-level checks of the duplicate frame filter and their binding.
module ddf_checker
  import ddf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_is_duplicate,
  input logic [COUNT_OUT_W-1:0] out_entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_duplicate)
                               && $stable(out_entry_count))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new word taken while one is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TABLE_DEPTH >= 2048) || (32'(out_entry_count) <= 32'(TABLE_DEPTH)))
    else $error("entry count above table depth");

  a_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_duplicate |-> (out_entry_count != '0) || (TABLE_DEPTH >= 2047))
    else $error("duplicate reported with an empty table");

endmodule

bind duplicate_frame_filter ddf_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ddf_checker (.*);
